>>> rtl/core/bpl_pkg.sv
// Shared types, codes and constants for the bounded positional list.
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

	// Default capacity of the list
	localparam int LIST_DEPTH_DEF = 32;

	// Width used for position and count compares (covers a capacity up to 64, plus one)
	localparam int CMPW = 8;

	// Command opcodes
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_AT    = 3'd1,
		OP_INS_BACK  = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_AT    = 3'd4,
		OP_DEL_BACK  = 3'd5,
		OP_LIST_FWD  = 3'd6,
		OP_LIST_REV  = 3'd7
	} opcode_t;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// Walk pointer update selection
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_INS,
		PTR_DEL,
		PTR_FWD,
		PTR_REV,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	// Memory read address selection, relative to the walk pointer
	typedef enum logic [2:0] {
		RD_P,
		RD_PM1,
		RD_PM2,
		RD_PP1,
		RD_PP2
	} rd_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       cmd_load;
		ptr_op_t    ptr_op;
		rd_sel_t    rd_sel;
		logic       wr_shift;
		logic       wr_value;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       out_load;
		logic       out_list;
		logic [1:0] out_status;
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		opcode_t op;
		logic    empty;
		logic    one;
		logic    full;
		logic    ins_bad;
		logic    del_bad;
		logic    ins_none;
		logic    del_none;
		logic    ins_step_end;
		logic    del_step_end;
		logic    list_end;
		logic    out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/core/bpl_datapath.sv
// Datapath: element memory, count, command registers, walk pointer and output register.
`timescale 1ns / 1ps
`default_nettype none

module bpl_datapath
	import bpl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctl_t               ctl,
	output sts_t                    sts,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      element,
	output logic [1:0]              status,
	output logic                    last_item,
	output logic [5:0]              length
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic [31:0]        mem [LIST_DEPTH];
	logic [31:0]        rdata_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      ptr_q;
	opcode_t            op_q;
	logic [31:0]        value_q;
	logic [5:0]         pos_q;
	logic               out_valid_q;
	logic [31:0]        element_q;
	logic [1:0]         status_q;
	logic               last_q;
	logic [5:0]         length_q;

	logic [CMPW-1:0]    cnt_w;
	logic [CMPW-1:0]    pos_w;
	logic [CMPW-1:0]    ptr_w;
	logic [CMPW-1:0]    idx_w;
	logic [AW-1:0]      idx;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;
	logic               out_free;

	assign cnt_w    = CMPW'(count_q);
	assign pos_w    = CMPW'(pos_q);
	assign ptr_w    = CMPW'(ptr_q);
	assign out_free = !out_valid_q || !out_stall;

	// Target index of the current insert or delete
	always_comb begin
		case (op_q)
			OP_INS_BACK: idx_w = cnt_w;
			OP_INS_AT:   idx_w = (count_q == '0) ? '0 : pos_w - CMPW'(1);
			OP_DEL_BACK: idx_w = cnt_w - CMPW'(1);
			OP_DEL_AT:   idx_w = (count_q == CW'(1)) ? '0 : pos_w - CMPW'(1);
			default:     idx_w = '0;
		endcase
	end
	assign idx = idx_w[AW-1:0];

	// Status flags for the controller
	always_comb begin
		sts.op           = op_q;
		sts.empty        = (count_q == '0);
		sts.one          = (count_q == CW'(1));
		sts.full         = (cnt_w == CMPW'(LIST_DEPTH));
		sts.ins_bad      = (pos_w == '0) || (pos_w > cnt_w + CMPW'(1));
		sts.del_bad      = (pos_w == '0) || (pos_w > cnt_w);
		sts.ins_none     = (idx_w == cnt_w);
		sts.del_none     = (idx_w + CMPW'(1) == cnt_w);
		sts.ins_step_end = (ptr_w == idx_w + CMPW'(1));
		sts.del_step_end = (ptr_w + CMPW'(2) == cnt_w);
		sts.list_end     = (op_q == OP_LIST_FWD) ? (ptr_w + CMPW'(1) == cnt_w)
		                                         : (ptr_q == '0);
		sts.out_free     = out_free;
	end

	// Read address relative to the walk pointer
	always_comb begin
		case (ctl.rd_sel)
			RD_PM1:  rd_addr = ptr_q - AW'(1);
			RD_PM2:  rd_addr = ptr_q - AW'(2);
			RD_PP1:  rd_addr = ptr_q + AW'(1);
			RD_PP2:  rd_addr = ptr_q + AW'(2);
			default: rd_addr = ptr_q;
		endcase
	end

	// Write port: shifted word at the pointer, or new value at the target index
	assign wr_addr = ctl.wr_value ? idx : ptr_q;
	assign wr_data = ctl.wr_value ? value_q : rdata_q;

	// Element memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_shift || ctl.wr_value) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Command registers and walk pointer
	always_ff @(posedge clk) begin
		if (ctl.cmd_load) begin
			op_q    <= opcode_t'(opcode);
			value_q <= value;
			pos_q   <= position;
		end
		case (ctl.ptr_op)
			PTR_INS: ptr_q <= count_q[AW-1:0];
			PTR_DEL: ptr_q <= idx;
			PTR_FWD: ptr_q <= '0;
			PTR_REV: ptr_q <= AW'(count_q - CW'(1));
			PTR_INC: ptr_q <= ptr_q + AW'(1);
			PTR_DEC: ptr_q <= ptr_q - AW'(1);
			default: ptr_q <= ptr_q;
		endcase
	end

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			element_q <= ctl.out_list ? rdata_q : '0;
			status_q  <= ctl.out_status;
			last_q    <= ctl.out_list ? sts.list_end : 1'b1;
			length_q  <= 6'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign element   = element_q;
	assign status    = status_q;
	assign last_item = last_q;
	assign length    = length_q;

endmodule

`default_nettype wire

>>> rtl/core/bpl_controller.sv
// Controller: sequences decode, shift walks, listing and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module bpl_controller
	import bpl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_PRIME,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_PRIME,
		S_DEL_SHIFT,
		S_DEL_FIN,
		S_LIST_RD,
		S_LIST_LOAD,
		S_RESP
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] code_q, code_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d        = state_q;
		code_d         = code_q;
		ctl            = '0;
		ctl.ptr_op     = PTR_HOLD;
		ctl.rd_sel     = RD_P;
		ctl.out_status = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.cmd_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				code_d  = ST_OK;
				state_d = S_RESP;
				unique case (sts.op) inside
					OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
						if (sts.op == OP_INS_AT && !sts.empty && sts.ins_bad) begin
							code_d = ST_BADPOS;
						end else if (sts.full) begin
							code_d = ST_FULL;
						end else if (sts.ins_none) begin
							state_d = S_INS_PUT;
						end else begin
							ctl.ptr_op = PTR_INS;
							state_d    = S_INS_PRIME;
						end
					end
					OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
						if (sts.empty) begin
							code_d = ST_EMPTY;
						end else if (sts.op == OP_DEL_AT && !sts.one && sts.del_bad) begin
							code_d = ST_BADPOS;
						end else if (sts.del_none) begin
							state_d = S_DEL_FIN;
						end else begin
							ctl.ptr_op = PTR_DEL;
							state_d    = S_DEL_PRIME;
						end
					end
					default: begin
						if (sts.empty) begin
							code_d = ST_EMPTY;
						end else begin
							ctl.ptr_op = (sts.op == OP_LIST_FWD) ? PTR_FWD : PTR_REV;
							state_d    = S_LIST_RD;
						end
					end
				endcase
			end
			// Insert: move words up one place, from the back down to the target
			S_INS_PRIME: begin
				ctl.rd_sel = RD_PM1;
				state_d    = S_INS_SHIFT;
			end
			S_INS_SHIFT: begin
				ctl.wr_shift = 1'b1;
				if (sts.ins_step_end) begin
					state_d = S_INS_PUT;
				end else begin
					ctl.rd_sel = RD_PM2;
					ctl.ptr_op = PTR_DEC;
				end
			end
			S_INS_PUT: begin
				ctl.wr_value = 1'b1;
				ctl.cnt_inc  = 1'b1;
				state_d      = S_RESP;
			end
			// Delete: move words down one place, from the target to the back
			S_DEL_PRIME: begin
				ctl.rd_sel = RD_PP1;
				state_d    = S_DEL_SHIFT;
			end
			S_DEL_SHIFT: begin
				ctl.wr_shift = 1'b1;
				if (sts.del_step_end) begin
					state_d = S_DEL_FIN;
				end else begin
					ctl.rd_sel = RD_PP2;
					ctl.ptr_op = PTR_INC;
				end
			end
			S_DEL_FIN: begin
				ctl.cnt_dec = 1'b1;
				state_d     = S_RESP;
			end
			// Listing: one read, then one output transfer per element
			S_LIST_RD: begin
				state_d = S_LIST_LOAD;
			end
			S_LIST_LOAD: begin
				if (sts.out_free) begin
					ctl.out_load   = 1'b1;
					ctl.out_list   = 1'b1;
					ctl.out_status = ST_OK;
					if (sts.list_end) begin
						state_d = S_IDLE;
					end else begin
						ctl.ptr_op = (sts.op == OP_LIST_FWD) ? PTR_INC : PTR_DEC;
						state_d    = S_LIST_RD;
					end
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and status code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bounded_positional_list.sv
// Bounded positional list (deque with positional access): top level.
//
// Input channel (in_valid / in_stall): one command per transfer, carrying
// opcode, value and position. The block takes one command at a time and
// holds in_stall high from the cycle after a transfer until the command's
// last result has been loaded into the output register.
// Output channel (out_valid / out_stall): element, status, last_item and
// length. A listing of a non-empty list gives one transfer per element with
// last_item on the final one; every other command gives a single transfer.
// Each command is decoded first; an insert or delete then moves the stored
// words that must shift, one place each, and writes the new value or lowers
// the count before its status is loaded; a listing reads and loads each
// element in turn. The next command can transfer in the cycle after the
// last result is loaded. The words move one per cycle through the
// single-read, single-write element memory.
// Reset clears the count and the output valid; memory contents are not
// cleared and nothing is read beyond the count. When the receiver stalls,
// the output register holds its result and the controller waits.
`timescale 1ns / 1ps
`default_nettype none

module bounded_positional_list
	import bpl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         position,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      element,
	output logic [1:0]              status,
	output logic                    last_item,
	output logic [5:0]              length
);

	ctl_t ctl;
	sts_t sts;

	bpl_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	bpl_datapath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.opcode    (opcode),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.element   (element),
		.status    (status),
		.last_item (last_item),
		.length    (length)
	);

endmodule

`default_nettype wire

>>> rtl/core/bpl_checker.sv
// Port-level checks for the bounded positional list, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bpl_checker
	import bpl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] element,
	input wire logic [1:0]         status,
	input wire logic               last_item,
	input wire logic [5:0]         length
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(status)
			&& $stable(last_item) && $stable(length))
		else $error("stalled result changed");

	// Error results are single, final and carry no element
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last_item && element == '0)
		else $error("error result not final or element nonzero");

	// Only a listing gives non-final results, and those are all ok
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_item |-> status == ST_OK)
		else $error("non-final result with error status");

	// Full is reported only at capacity
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> length == 6'(LIST_DEPTH))
		else $error("full status below capacity");

endmodule

bind bounded_positional_list bpl_checker #(
	.LIST_DEPTH (LIST_DEPTH)
) u_bpl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.element   (element),
	.status    (status),
	.last_item (last_item),
	.length    (length)
);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the bounded positional list.
`timescale 1ns / 1ps

import bpl_pkg::*;

// One output transfer of the list
typedef struct {
	logic signed [31:0] element;
	logic [1:0]         status;
	logic               last_item;
	logic [5:0]         length;
} list_result_t;

// Shadow list plus the queue of results the block still owes
class list_scoreboard;
	logic signed [31:0] words[$];
	list_result_t       results_owed[$];
	int                 failures;
	int                 commands;
	int                 checked;
	int                 peak_len;
	int                 op_hits[8];
	int                 status_hits[4];

	function int count();
		return words.size();
	endfunction

	function int pending();
		return results_owed.size();
	endfunction

	// Apply one accepted command to the shadow list and queue its results
	function void apply_command(opcode_t op, logic signed [31:0] v, logic [5:0] p);
		int n;
		int pi;
		logic [1:0] st;
		list_result_t r;
		n = words.size();
		pi = int'(p);
		st = ST_OK;
		commands++;
		op_hits[op]++;
		case (op)
		OP_INS_FRONT, OP_INS_BACK: begin
			if (n >= LIST_DEPTH_DEF) st = ST_FULL;
			else if (op == OP_INS_FRONT) words.push_front(v);
			else words.push_back(v);
		end
		OP_INS_AT: begin
			// empty list takes the value whatever the position; position checked before full
			if (n == 0) words.push_back(v);
			else if (pi == 0 || pi > n + 1) st = ST_BADPOS;
			else if (n >= LIST_DEPTH_DEF) st = ST_FULL;
			else if (pi == n + 1) words.push_back(v);
			else words.insert(pi - 1, v);
		end
		OP_DEL_FRONT, OP_DEL_BACK: begin
			if (n == 0) st = ST_EMPTY;
			else if (op == OP_DEL_FRONT) void'(words.pop_front());
			else void'(words.pop_back());
		end
		OP_DEL_AT: begin
			// a lone element goes whatever the position
			if (n == 0) st = ST_EMPTY;
			else if (n == 1) words.delete(0);
			else if (pi == 0 || pi > n) st = ST_BADPOS;
			else words.delete(pi - 1);
		end
		default: begin
			// listings: one transfer per element, or one empty status
			if (n == 0) begin
				st = ST_EMPTY;
			end else begin
				for (int i = 0; i < n; i++) begin
					r.element = (op == OP_LIST_FWD) ? words[i] : words[n - 1 - i];
					r.status = ST_OK;
					r.last_item = (i == n - 1);
					r.length = 6'(n);
					results_owed.push_back(r);
				end
				return;
			end
		end
		endcase
		if (words.size() > peak_len) peak_len = words.size();
		r.element = '0;
		r.status = st;
		r.last_item = 1'b1;
		r.length = 6'(words.size());
		results_owed.push_back(r);
	endfunction

	// Compare one output transfer with the oldest owed result
	function void match_result(logic signed [31:0] e, logic [1:0] s, logic l, logic [5:0] len);
		list_result_t x;
		if (results_owed.size() == 0) begin
			$error("result with nothing owed: element %0d status %0d", e, s);
			failures++;
			return;
		end
		x = results_owed.pop_front();
		checked++;
		if (!$isunknown(s)) status_hits[s]++;
		if (e !== x.element) begin
			$error("element: expected %0d, got %0d", x.element, e);
			failures++;
		end
		if (s !== x.status) begin
			$error("status: expected %0d, got %0d", x.status, s);
			failures++;
		end
		if (l !== x.last_item) begin
			$error("last_item: expected %0d, got %0d", x.last_item, l);
			failures++;
		end
		if (len !== x.length) begin
			$error("length: expected %0d, got %0d", x.length, len);
			failures++;
		end
	endfunction
endclass

module tb_top;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         opcode = '0;
	logic signed [31:0] value = '0;
	logic [5:0]         position = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] element;
	logic [1:0]         status;
	logic               last_item;
	logic [5:0]         length;

	int  src_idle_pct = 0;
	int  sink_stall_pct = 0;
	bit  hold_req = 1'b0;

	list_scoreboard book = new();

	bounded_positional_list #(
		.LIST_DEPTH(LIST_DEPTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element(element),
		.status(status),
		.last_item(last_item),
		.length(length)
	);

	always #6 clk = ~clk;

	// Receiver: random stall, or a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (150) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.match_result(element, status, last_item, length);
	end

	// Offer one command until it transfers, with random idle cycles ahead of it
	task automatic push_cmd(opcode_t op, logic signed [31:0] v, logic [5:0] p);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		value <= v;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		book.apply_command(op, v, p);
	endtask

	// Stop offering until every owed result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 3) return 32'sh8000_0000;
		if (r < 6) return 32'sh7fff_ffff;
		if (r < 8) return '0;
		if (r < 10) return -32'sd1;
		return $urandom;
	endfunction

	// Mostly in-range positions, some anywhere in the 6-bit field
	function automatic logic [5:0] pick_position(opcode_t op, int n);
		if ($urandom_range(99) < 15) return 6'($urandom_range(63));
		if (op == OP_DEL_AT) return 6'($urandom_range(n > 0 ? n : 1, 1));
		return 6'($urandom_range(n + 1, 1));
	endfunction

	// Random commands: growing bias in the first half, shrinking in the second
	task automatic random_cmds(int n_items);
		int grow;
		int r;
		opcode_t op;
		for (int k = 0; k < n_items; k++) begin
			grow = (k < n_items / 2) ? 70 : 20;
			r = $urandom_range(99);
			if (r < 10) op = $urandom_range(1) ? OP_LIST_FWD : OP_LIST_REV;
			else if (r < 10 + grow) op = opcode_t'($urandom_range(2));
			else op = opcode_t'(3 + $urandom_range(2));
			push_cmd(op, pick_value(), pick_position(op, book.count()));
		end
	endtask

	// Stimulus
	initial begin
		opcode_t op;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, field extremes, every position check
		push_cmd(OP_LIST_FWD, 0, 0);
		push_cmd(OP_LIST_REV, 0, 0);
		push_cmd(OP_DEL_FRONT, 0, 0);
		push_cmd(OP_DEL_BACK, 0, 0);
		push_cmd(OP_DEL_AT, 0, 5);
		push_cmd(OP_INS_AT, 32'sh8000_0000, 0);
		push_cmd(OP_INS_FRONT, 32'sh7fff_ffff, 0);
		push_cmd(OP_INS_BACK, -32'sd1, 63);
		push_cmd(OP_INS_AT, 32'sd11, 0);
		push_cmd(OP_INS_AT, 32'sd12, 5);
		push_cmd(OP_INS_AT, 32'sd13, 63);
		push_cmd(OP_INS_AT, 32'sd0, 1);
		push_cmd(OP_INS_AT, 32'sh1234_5678, 5);
		push_cmd(OP_INS_AT, -32'sh2aaa_5555, 3);
		push_cmd(OP_LIST_FWD, 0, 0);
		push_cmd(OP_LIST_REV, 0, 0);
		push_cmd(OP_DEL_AT, 0, 0);
		push_cmd(OP_DEL_AT, 0, 7);
		push_cmd(OP_DEL_AT, 0, 3);
		push_cmd(OP_DEL_AT, 0, 5);
		push_cmd(OP_DEL_AT, 0, 1);
		push_cmd(OP_DEL_FRONT, 0, 0);
		push_cmd(OP_DEL_BACK, 0, 0);
		push_cmd(OP_DEL_AT, 0, 42);
		push_cmd(OP_LIST_FWD, 0, 0);
		drain_results();

		// fill to capacity, then hit the full cases
		while (book.count() < LIST_DEPTH_DEF) begin
			op = opcode_t'($urandom_range(2));
			push_cmd(op, pick_value(), 6'($urandom_range(book.count() + 1, 1)));
		end
		push_cmd(OP_INS_FRONT, 32'sd1, 0);
		push_cmd(OP_INS_BACK, 32'sd2, 0);
		push_cmd(OP_INS_AT, 32'sd3, 10);
		push_cmd(OP_INS_AT, 32'sd4, 33);
		push_cmd(OP_INS_AT, 32'sd5, 40);

		// long receiver hold-off while commands keep coming
		hold_req = 1'b1;
		push_cmd(OP_LIST_FWD, 0, 0);
		push_cmd(OP_DEL_AT, 0, 33);
		push_cmd(OP_DEL_AT, 0, 32);
		push_cmd(OP_LIST_REV, 0, 0);
		push_cmd(OP_DEL_AT, 0, 1);
		drain_results();

		// random phases with different idle and stall rates
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 77;
				sink_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				sink_stall_pct = 77;
			end
			default: begin
				src_idle_pct = 15;
				sink_stall_pct = 15;
			end
			endcase
			random_cmds(28);
			drain_results();
		end

		// let any stray result show up
		repeat (LIST_DEPTH_DEF + 8) @(posedge clk);

		$display("Covered %0d commands (%0d of 8 opcodes), %0d results checked, peak length %0d.",
			book.commands, (book.op_hits[0] > 0) + (book.op_hits[1] > 0) +
			(book.op_hits[2] > 0) + (book.op_hits[3] > 0) + (book.op_hits[4] > 0) +
			(book.op_hits[5] > 0) + (book.op_hits[6] > 0) + (book.op_hits[7] > 0),
			book.checked, book.peak_len);
		$display("Statuses seen: ok %0d, empty %0d, bad position %0d, full %0d.",
			book.status_hits[0], book.status_hits[1], book.status_hits[2],
			book.status_hits[3]);
		if (book.failures == 0 && book.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest run (about 180 commands of up to 32 stalled results)
	initial begin
		#(10_000_000);
		$display("TEST FAILED");
		$finish;
	end
endmodule
